/* hw/rtl/brs_pkg.sv */
// brs_pkg: shared types and constants for the two-level bitonic reliability sorter
// used by brs_ctrl, brs_datapath and bitonic_reliability_sort_two_level
// no dependencies
package brs_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int LLR_W       = 8;
	localparam int MAG_W       = 5;
	localparam int IDX_W       = 6;
	localparam int KEY_SHIFT   = 2;

	localparam logic [MAG_W-1:0] MAG_LIMIT = 5'd31;
	localparam logic [MAG_W-1:0] PAD_MAG   = 5'd31;

	typedef enum logic [1:0] {
		WR_LOAD,
		WR_PAD,
		WR_A,
		WR_B
	} wr_src_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [MAG_W-1:0] mag;
	} entry_t;

	typedef struct packed {
		logic    wr_en;
		wr_src_t wr_src;
		logic    rd_en;
		logic    desc;
	} dp_cmd_t;

	typedef struct packed {
		logic swap;
	} dp_sts_t;

endpackage

/* hw/rtl/brs_datapath.sv */
// brs_datapath: element memory, magnitude clipping, compare-exchange and config register
// depends on brs_pkg; driven by brs_ctrl
module brs_datapath #(
	parameter int MAX_LEN = brs_pkg::MAX_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic signed [brs_pkg::LLR_W-1:0]  llr,
	input  brs_pkg::dp_cmd_t                  cmd,
	input  logic [$clog2(MAX_LEN)-1:0]        wr_addr,
	input  logic [$clog2(MAX_LEN)-1:0]        rd_addr_a,
	input  logic [$clog2(MAX_LEN)-1:0]        rd_addr_b,
	output brs_pkg::dp_sts_t                  sts,
	output logic [brs_pkg::IDX_W-1:0]         order_index,
	output logic [brs_pkg::MAG_W-1:0]         sorted_mag
);

	localparam int AW    = $clog2(MAX_LEN);
	localparam int DEPTH = 1 << AW;

	brs_pkg::entry_t mem [DEPTH];
	brs_pkg::entry_t rd_a_q;
	brs_pkg::entry_t rd_b_q;
	brs_pkg::entry_t wr_data;

	logic                        mode_q;
	logic [brs_pkg::LLR_W-1:0]   llr_u;
	logic [brs_pkg::LLR_W-1:0]   llr_abs;
	logic [brs_pkg::MAG_W-1:0]   llr_mag;
	logic [brs_pkg::MAG_W-1:0]   key_a;
	logic [brs_pkg::MAG_W-1:0]   key_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// magnitude clipped to five bits
	assign llr_u   = llr;
	assign llr_abs = llr_u[brs_pkg::LLR_W-1] ? (~llr_u + brs_pkg::LLR_W'(1)) : llr_u;
	assign llr_mag = (llr_abs > brs_pkg::LLR_W'(brs_pkg::MAG_LIMIT)) ? brs_pkg::MAG_LIMIT
		: llr_abs[brs_pkg::MAG_W-1:0];

	always_comb begin
		case (cmd.wr_src)
			brs_pkg::WR_LOAD: begin
				wr_data.idx = brs_pkg::IDX_W'(wr_addr);
				wr_data.mag = llr_mag;
			end
			brs_pkg::WR_PAD: begin
				wr_data.idx = brs_pkg::IDX_W'(wr_addr);
				wr_data.mag = brs_pkg::PAD_MAG;
			end
			brs_pkg::WR_A: wr_data = rd_a_q;
			default:       wr_data = rd_b_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	// mode 0 keeps only the coarse key
	assign key_a = mode_q ? rd_a_q.mag : (rd_a_q.mag >> brs_pkg::KEY_SHIFT);
	assign key_b = mode_q ? rd_b_q.mag : (rd_b_q.mag >> brs_pkg::KEY_SHIFT);

	assign sts.swap = cmd.desc ? (key_a < key_b) : (key_a > key_b);

	assign order_index = rd_a_q.idx;
	assign sorted_mag  = rd_a_q.mag;

endmodule

/* hw/rtl/brs_ctrl.sv */
// brs_ctrl: load, pad, bitonic network sequencing and emission state machine
// depends on brs_pkg; commands brs_datapath
module brs_ctrl #(
	parameter int MAX_LEN = brs_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        end_of_order,
	output brs_pkg::dp_cmd_t            cmd,
	input  brs_pkg::dp_sts_t            sts,
	output logic [$clog2(MAX_LEN)-1:0]  wr_addr,
	output logic [$clog2(MAX_LEN)-1:0]  rd_addr_a,
	output logic [$clog2(MAX_LEN)-1:0]  rd_addr_b
);

	localparam int AW    = $clog2(MAX_LEN);
	localparam int DEPTH = 1 << AW;
	localparam int NW    = AW + 1;

	typedef enum logic [2:0] {
		IDLE,
		PREP,
		PAD,
		CMP_RD,
		CMP_WA,
		CMP_WB,
		EMIT_RD,
		EMIT
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   count_q;
	logic [NW-1:0]   neff_q;
	logic [NW-1:0]   pad_q;
	logic [NW-1:0]   rank_q;
	logic [NW-1:0]   w_q;
	logic [AW-1:0]   j_q;
	logic [AW-1:0]   k_q;
	logic            out_valid_q;
	logic            eoo_q;

	logic [NW-1:0]   neff_c;
	logic [AW-1:0]   mask;
	logic [AW-1:0]   idx_lo;
	logic [AW-1:0]   idx_hi;
	logic            last_k;

	assign in_ready     = (state_q == IDLE);
	assign out_valid    = out_valid_q;
	assign end_of_order = eoo_q;

	// smallest power of two not below the count
	always_comb begin
		neff_c = NW'(DEPTH);
		for (int b = AW; b >= 0; b--) begin
			if ((NW'(1) << b) >= count_q) begin
				neff_c = NW'(1) << b;
			end
		end
	end

	// comparator k of the current stage, bit j cleared for the lower element
	assign mask   = j_q - AW'(1);
	assign idx_lo = ((k_q & ~mask) << 1) | (k_q & mask);
	assign idx_hi = idx_lo | j_q;
	assign last_k = (k_q == AW'((neff_q >> 1) - NW'(1)));

	always_comb begin
		cmd        = '0;
		cmd.wr_src = brs_pkg::WR_LOAD;
		cmd.desc   = |({1'b0, idx_lo} & w_q);
		wr_addr    = count_q[AW-1:0];
		rd_addr_a  = idx_lo;
		rd_addr_b  = idx_hi;
		unique case (state_q)
			IDLE: begin
				cmd.wr_en = in_valid && (count_q < NW'(MAX_LEN));
			end
			PAD: begin
				cmd.wr_en  = (pad_q < neff_q);
				cmd.wr_src = brs_pkg::WR_PAD;
				wr_addr    = pad_q[AW-1:0];
			end
			CMP_RD: begin
				cmd.rd_en = 1'b1;
			end
			CMP_WA: begin
				cmd.wr_en  = sts.swap;
				cmd.wr_src = brs_pkg::WR_B;
				wr_addr    = idx_lo;
			end
			CMP_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = brs_pkg::WR_A;
				wr_addr    = idx_hi;
			end
			EMIT_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr_a = rank_q[AW-1:0];
				rd_addr_b = rank_q[AW-1:0];
			end
			PREP, EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			neff_q      <= '0;
			pad_q       <= '0;
			rank_q      <= '0;
			w_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			eoo_q       <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						if (count_q < NW'(MAX_LEN)) begin
							count_q <= count_q + NW'(1);
						end
						if (last) begin
							state_q <= PREP;
						end
					end
				end
				PREP: begin
					neff_q  <= neff_c;
					pad_q   <= count_q;
					state_q <= PAD;
				end
				PAD: begin
					if (pad_q < neff_q) begin
						pad_q <= pad_q + NW'(1);
					end else if (neff_q == NW'(1)) begin
						rank_q  <= '0;
						state_q <= EMIT_RD;
					end else begin
						w_q     <= NW'(2);
						j_q     <= AW'(1);
						k_q     <= '0;
						state_q <= CMP_RD;
					end
				end
				CMP_RD: begin
					state_q <= CMP_WA;
				end
				CMP_WA, CMP_WB: begin
					if (state_q == CMP_WB || !sts.swap) begin
						state_q <= CMP_RD;
						if (last_k) begin
							k_q <= '0;
							if (j_q == AW'(1)) begin
								if (w_q == neff_q) begin
									rank_q  <= '0;
									state_q <= EMIT_RD;
								end else begin
									w_q <= w_q << 1;
									j_q <= w_q[AW-1:0];
								end
							end else begin
								j_q <= j_q >> 1;
							end
						end else begin
							k_q <= k_q + AW'(1);
						end
					end else begin
						state_q <= CMP_WB;
					end
				end
				EMIT_RD: begin
					out_valid_q <= 1'b1;
					eoo_q       <= (rank_q == count_q - NW'(1));
					state_q     <= EMIT;
				end
				EMIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (eoo_q) begin
							count_q <= '0;
							state_q <= IDLE;
						end else begin
							rank_q  <= rank_q + NW'(1);
							state_q <= EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/bitonic_reliability_sort_two_level.sv */
// bitonic_reliability_sort_two_level: top level of the reliability sorter
// depends on brs_pkg, brs_ctrl, brs_datapath
//
// Input words (llr, last) arrive on in_valid/in_ready, one per cycle while the
// block is loading. Each magnitude is clipped to 31; up to MAX_LEN words are
// kept, later ones are dropped. The word with last set starts the sort: the
// block is padded to the next power of two with magnitude 31, then an
// ascending bitonic network runs on a two-read, one-write element memory.
// Each compare-exchange reads the pair and, only when the pair swaps, writes
// the lower element and then the upper one; a padded block of N elements
// needs log2(N)*(log2(N)+1)/2 stages of N/2 exchanges, after one pad write
// per padded slot. Results then leave on out_valid/out_ready, one word per
// loaded element in sorted order, each read from memory and then presented;
// a stall simply holds the presented word. end_of_order marks the final
// rank, after which in_ready returns. in_ready is low for the whole sort and
// emission. compare_mode (cfg_wr_en/cfg_wr_data) resets to 1: full magnitude
// compare; 0 compares only the top three magnitude bits. Reset clears the
// control state only, no memory clearing pass is needed.
module bitonic_reliability_sort_two_level #(
	parameter int MAX_LEN = brs_pkg::MAX_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [brs_pkg::LLR_W-1:0]  llr,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [brs_pkg::IDX_W-1:0]         order_index,
	output logic [brs_pkg::MAG_W-1:0]         sorted_mag,
	output logic                              end_of_order
);

	localparam int AW = $clog2(MAX_LEN);

	brs_pkg::dp_cmd_t  cmd;
	brs_pkg::dp_sts_t  sts;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;

	brs_ctrl #(
		.MAX_LEN (MAX_LEN)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.end_of_order (end_of_order),
		.cmd          (cmd),
		.sts          (sts),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b)
	);

	brs_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.llr         (llr),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.sts         (sts),
		.order_index (order_index),
		.sorted_mag  (sorted_mag)
	);

	// loading and emitting never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("output word pending while accepting input");

	// a last word closes the block
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input still accepted after last word");

	// the final rank reopens the input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && end_of_order |=> in_ready && !out_valid)
		else $error("block not released after final rank");

	// no write to memory while a result is presented
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd.wr_en)
		else $error("memory written during emission");

endmodule
